// File: hw/rtl/tpms_pkg.sv
package tpms_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int DEC_BYTES = FRAME_BYTES / 2;
  localparam int DEC_W = $clog2(DEC_BYTES);

  localparam logic [2:0] STAT_NEW       = 3'd0;
  localparam logic [2:0] STAT_DUP       = 3'd1;
  localparam logic [2:0] STAT_BAD_SUM   = 3'd2;
  localparam logic [2:0] STAT_BAD_MAN   = 3'd3;
  localparam logic [2:0] STAT_OUT_RANGE = 3'd4;

  localparam logic [1:0] REG_DUP_WINDOW = 2'd0;
  localparam logic [1:0] REG_MAX_PRES   = 2'd1;
  localparam logic [1:0] REG_MIN_TEMP   = 2'd2;
  localparam logic [1:0] REG_MAX_TEMP   = 2'd3;

  localparam logic [15:0] DUP_WINDOW_RST = 16'd2000;
  localparam logic [11:0] MAX_PRES_RST   = 12'd496;
  localparam logic [7:0]  MIN_TEMP_RST   = 8'd22;
  localparam logic [7:0]  MAX_TEMP_RST   = 8'd132;

  localparam logic [7:0]  FIRST_PREV     = 8'h01;
  localparam logic [26:0] PSI_SCALE      = 27'd23762;
  localparam logic [12:0] TEMP_MUL       = 13'd18;
  localparam logic [12:0] TEMP_OFS       = 13'd580;

  typedef struct packed {
    logic [15:0] dup_window_ms;
    logic [11:0] max_pressure_code;
    logic [7:0]  min_temp_code;
    logic [7:0]  max_temp_code;
  } cfg_t;

  typedef struct packed {
    logic [DEC_BYTES-1:0][7:0] dbytes;
    logic                      man_err;
    logic [10:0]               byte_sum;
    logic [31:0]               time_ms;
  } frame_t;

endpackage

// File: hw/rtl/tpms_if.sv
interface tpms_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  raw_byte;
  logic        frame_start;
  logic [31:0] time_ms;

  modport source (output valid, raw_byte, frame_start, time_ms, input ready);
  modport sink (input valid, raw_byte, frame_start, time_ms, output ready);
endinterface

interface tpms_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [23:0]        sensor_id;
  logic [11:0]        pressure_code;
  logic [18:0]        pressure_psi_q8;
  logic signed [12:0] temp_tenths_f;
  logic               low_battery;
  logic               fast_leak;
  logic [15:0]        dup_count;

  modport source (output valid, status, sensor_id, pressure_code, pressure_psi_q8,
                  temp_tenths_f, low_battery, fast_leak, dup_count, input ready);
  modport sink (input valid, status, sensor_id, pressure_code, pressure_psi_q8,
                temp_tenths_f, low_battery, fast_leak, dup_count, output ready);
endinterface

// File: hw/rtl/tpms_front.sv
module tpms_front (
  input  logic              clk,
  input  logic              rst,
  tpms_byte_if.sink         byte_ch,
  input  logic              q_full,
  output logic              q_push,
  output tpms_pkg::frame_t  q_data
);

  logic [tpms_pkg::IDX_W-1:0] byte_index;
  logic [tpms_pkg::IDX_W-1:0] idx_eff;
  logic [7:0]                 prev_raw;
  logic [3:0]                 high_nibble;
  logic                       man_err;
  logic [10:0]                byte_sum;
  logic [7:0]                 dstore [tpms_pkg::DEC_BYTES];

  logic                       accept;
  logic                       first;
  logic                       last;
  logic [7:0]                 prev;
  logic [7:0]                 shifted;
  logic [3:0]                 nib;
  logic                       bad;
  logic [7:0]                 dbyte;
  logic [tpms_pkg::DEC_W-1:0] k;
  logic                       man_err_next;
  logic [10:0]                byte_sum_next;

  assign byte_ch.ready = !q_full;
  assign accept = byte_ch.valid && byte_ch.ready;

  assign idx_eff = byte_ch.frame_start ? '0 : byte_index;
  assign first = (idx_eff == '0);
  assign last = (idx_eff == tpms_pkg::IDX_W'(tpms_pkg::FRAME_BYTES - 1));
  assign prev = first ? tpms_pkg::FIRST_PREV : prev_raw;
  assign shifted = {prev[1:0], byte_ch.raw_byte[7:2]};
  assign k = idx_eff[tpms_pkg::IDX_W-1:1];
  assign dbyte = {high_nibble, nib};

  // 10 -> 0, 01 -> 1, equal bits flag a broken pair
  always_comb begin
    bad = 1'b0;
    for (int p = 0; p < 4; p++) begin
      nib[p] = (shifted[2*p+1 -: 2] == 2'b01);
      if (shifted[2*p+1] == shifted[2*p]) begin
        bad = 1'b1;
      end
    end
  end

  always_comb begin
    man_err_next = (first ? 1'b0 : man_err) | bad;
    byte_sum_next = first ? 11'd0 : byte_sum;
    if (idx_eff[0] && (k != '0)) begin
      byte_sum_next = byte_sum_next + 11'(dbyte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      prev_raw <= '0;
      high_nibble <= '0;
      man_err <= 1'b0;
      byte_sum <= '0;
    end else if (accept) begin
      byte_index <= last ? '0 : idx_eff + 1'b1;
      prev_raw <= byte_ch.raw_byte;
      man_err <= man_err_next;
      byte_sum <= byte_sum_next;
      if (!idx_eff[0]) begin
        high_nibble <= nib;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && idx_eff[0]) begin
      dstore[k] <= dbyte;
    end
  end

  always_comb begin
    for (int j = 0; j < tpms_pkg::DEC_BYTES - 1; j++) begin
      q_data.dbytes[j] = dstore[j];
    end
    q_data.dbytes[tpms_pkg::DEC_BYTES-1] = dbyte;
    q_data.man_err = man_err_next;
    q_data.byte_sum = byte_sum_next;
    q_data.time_ms = byte_ch.time_ms;
  end

  assign q_push = accept && last;

endmodule

// File: hw/rtl/tpms_queue.sv
module tpms_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tpms_pkg::frame_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output tpms_pkg::frame_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tpms_pkg::frame_t        entries [DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [$clog2(DEPTH+1)-1:0] count;

  assign full = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign empty = (count == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/tpms_back.sv
module tpms_back (
  input  logic             clk,
  input  logic             rst,
  input  tpms_pkg::cfg_t   cfg,
  input  logic             q_empty,
  input  tpms_pkg::frame_t q_head,
  output logic             q_pop,
  tpms_result_if.source    result_ch
);

  logic        logged_valid;
  logic [23:0] logged_id;
  logic [11:0] logged_pressure;
  logic [7:0]  logged_temp;
  logic [1:0]  logged_flags;
  logic [31:0] logged_time;
  logic [15:0] logged_dups;

  logic [23:0] id;
  logic [11:0] pc;
  logic [7:0]  tb;
  logic [1:0]  flags;
  logic [7:0]  chk;
  logic [26:0] psi_prod;
  logic [12:0] temp_f;
  logic [31:0] age;
  logic        bad_sum;
  logic        out_range;
  logic        is_dup;
  logic [15:0] dups_next;
  logic [2:0]  status_next;

  assign q_pop = !q_empty && (!result_ch.valid || result_ch.ready);

  assign id = {q_head.dbytes[1], q_head.dbytes[2], q_head.dbytes[3]};
  assign pc = {q_head.dbytes[7][3:0], q_head.dbytes[4]};
  assign tb = q_head.dbytes[5];
  assign flags = {q_head.dbytes[6][5], q_head.dbytes[6][4]};
  assign chk = {|q_head.byte_sum[10:8], q_head.byte_sum[6:0]};
  assign psi_prod = 27'(pc) * tpms_pkg::PSI_SCALE;
  assign temp_f = 13'({5'd0, tb}) * tpms_pkg::TEMP_MUL - tpms_pkg::TEMP_OFS;
  assign age = q_head.time_ms - logged_time;

  assign bad_sum = (chk != q_head.dbytes[0]);
  assign out_range = (id == '0) || (pc > cfg.max_pressure_code) ||
                     (tb < cfg.min_temp_code) || (tb > cfg.max_temp_code);
  assign is_dup = logged_valid && (age < {16'd0, cfg.dup_window_ms}) &&
                  (id == logged_id) && (pc == logged_pressure) &&
                  (tb == logged_temp) && (flags == logged_flags);
  assign dups_next = (logged_dups == 16'hFFFF) ? logged_dups : logged_dups + 1'b1;

  always_comb begin
    if (q_head.man_err) begin
      status_next = tpms_pkg::STAT_BAD_MAN;
    end else if (bad_sum) begin
      status_next = tpms_pkg::STAT_BAD_SUM;
    end else if (out_range) begin
      status_next = tpms_pkg::STAT_OUT_RANGE;
    end else if (is_dup) begin
      status_next = tpms_pkg::STAT_DUP;
    end else begin
      status_next = tpms_pkg::STAT_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
      logged_valid <= 1'b0;
      logged_id <= '0;
      logged_pressure <= '0;
      logged_temp <= '0;
      logged_flags <= '0;
      logged_time <= '0;
      logged_dups <= '0;
    end else begin
      if (q_pop) begin
        result_ch.valid <= 1'b1;
      end else if (result_ch.ready) begin
        result_ch.valid <= 1'b0;
      end
      if (q_pop && status_next == tpms_pkg::STAT_DUP) begin
        logged_dups <= dups_next;
      end else if (q_pop && status_next == tpms_pkg::STAT_NEW) begin
        logged_valid <= 1'b1;
        logged_id <= id;
        logged_pressure <= pc;
        logged_temp <= tb;
        logged_flags <= flags;
        logged_time <= q_head.time_ms;
        logged_dups <= 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_ch.status <= status_next;
      if (status_next == tpms_pkg::STAT_BAD_MAN || status_next == tpms_pkg::STAT_BAD_SUM) begin
        result_ch.sensor_id <= '0;
        result_ch.pressure_code <= '0;
        result_ch.pressure_psi_q8 <= '0;
        result_ch.temp_tenths_f <= '0;
        result_ch.low_battery <= 1'b0;
        result_ch.fast_leak <= 1'b0;
      end else begin
        result_ch.sensor_id <= id;
        result_ch.pressure_code <= pc;
        result_ch.pressure_psi_q8 <= psi_prod[26:8];
        result_ch.temp_tenths_f <= temp_f;
        result_ch.low_battery <= flags[1];
        result_ch.fast_leak <= flags[0];
      end
      case (status_next)
        tpms_pkg::STAT_NEW: begin
          result_ch.dup_count <= 16'd1;
        end
        tpms_pkg::STAT_DUP: begin
          result_ch.dup_count <= dups_next;
        end
        default: begin
          result_ch.dup_count <= '0;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/tpms_frame_decoder.sv
// TPMS frame decoder: one raw byte accepted per cycle while the frame queue has room.
// One result per 16-byte frame: the frame is written to a small queue once its last
// byte is accepted, and the checking stage registers the result when it pops it.
// Input stalls while the queue is full: QUEUE_DEPTH frames wait behind a held result.
// Reset (rst, synchronous): byte count, log and config return to defaults;
// no clearing pass, the block takes bytes on the first cycle after reset.
module tpms_frame_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  tpms_byte_if.sink     byte_ch,
  tpms_result_if.source result_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  tpms_pkg::cfg_t   cfg;
  tpms_pkg::frame_t q_data;
  tpms_pkg::frame_t q_head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dup_window_ms <= tpms_pkg::DUP_WINDOW_RST;
      cfg.max_pressure_code <= tpms_pkg::MAX_PRES_RST;
      cfg.min_temp_code <= tpms_pkg::MIN_TEMP_RST;
      cfg.max_temp_code <= tpms_pkg::MAX_TEMP_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        tpms_pkg::REG_DUP_WINDOW: cfg.dup_window_ms <= pwdata[15:0];
        tpms_pkg::REG_MAX_PRES:   cfg.max_pressure_code <= pwdata[11:0];
        tpms_pkg::REG_MIN_TEMP:   cfg.min_temp_code <= pwdata[7:0];
        tpms_pkg::REG_MAX_TEMP:   cfg.max_temp_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tpms_pkg::REG_DUP_WINDOW: prdata = {16'd0, cfg.dup_window_ms};
      tpms_pkg::REG_MAX_PRES:   prdata = {20'd0, cfg.max_pressure_code};
      tpms_pkg::REG_MIN_TEMP:   prdata = {24'd0, cfg.min_temp_code};
      tpms_pkg::REG_MAX_TEMP:   prdata = {24'd0, cfg.max_temp_code};
      default:                  prdata = '0;
    endcase
  end

  tpms_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  tpms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tpms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .result_ch (result_ch)
  );

endmodule

// File: hw/rtl/tpms_checker.sv
module tpms_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic [2:0]  status,
  input logic [23:0] sensor_id,
  input logic [18:0] pressure_psi_q8,
  input logic [15:0] dup_count
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> (status == tpms_pkg::STAT_NEW || status == tpms_pkg::STAT_DUP ||
               status == tpms_pkg::STAT_BAD_SUM || status == tpms_pkg::STAT_BAD_MAN ||
               status == tpms_pkg::STAT_OUT_RANGE))
    else $error("status code out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && (status == tpms_pkg::STAT_BAD_SUM || status == tpms_pkg::STAT_BAD_MAN))
    |-> (sensor_id == '0 && pressure_psi_q8 == '0 && dup_count == '0))
    else $error("rejected frame carries data");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    (valid && status == tpms_pkg::STAT_NEW) |-> (dup_count == 16'd1 && sensor_id != '0))
    else $error("new packet with bad count or id");

  a_dup_count: assert property (@(posedge clk) disable iff (rst)
    (valid && status == tpms_pkg::STAT_DUP) |-> (dup_count > 16'd1 && sensor_id != '0))
    else $error("duplicate with bad count or id");

endmodule

bind tpms_frame_decoder tpms_checker u_tpms_checker (
  .clk             (clk),
  .rst             (rst),
  .valid           (result_ch.valid),
  .status          (result_ch.status),
  .sensor_id       (result_ch.sensor_id),
  .pressure_psi_q8 (result_ch.pressure_psi_q8),
  .dup_count       (result_ch.dup_count)
);

// File: tb/sv/tb_tpms_frame_decoder.sv
module tb_tpms_frame_decoder;
  import tpms_pkg::*;

  localparam int TOTAL_BYTES = 1450;
  localparam int PHASES = 5;
  localparam int STALL_LIMIT = 2000;

  typedef enum {IDLE_RECV_HEAVY, IDLE_SEND_HEAVY, IDLE_NONE} idle_plan_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] sensor_id;
    logic [11:0] pressure_code;
    logic [18:0] pressure_psi_q8;
    logic [12:0] temp_tenths_f;
    logic        low_battery;
    logic        fast_leak;
    logic [15:0] dup_count;
  } report_t;

  class frame_decode_tracker;
    logic [15:0] dup_window;
    logic [11:0] max_pres;
    logic [7:0]  min_temp;
    logic [7:0]  max_temp;

    int          byte_idx;
    logic [7:0]  prev_raw;
    logic [7:0]  dec [8];
    logic [3:0]  hi_nib;
    bit          man_err;
    logic [10:0] byte_sum;

    bit          log_valid;
    logic [23:0] log_id;
    logic [11:0] log_pres;
    logic [7:0]  log_temp;
    logic [1:0]  log_flags;
    logic [31:0] log_time;
    logic [15:0] log_dups;

    report_t     expected_reports[$];
    int          errors;
    int          reports_checked;
    int          status_seen [5];

    function new();
      dup_window = DUP_WINDOW_RST;
      max_pres = MAX_PRES_RST;
      min_temp = MIN_TEMP_RST;
      max_temp = MAX_TEMP_RST;
      byte_idx = 0;
      prev_raw = '0;
      hi_nib = '0;
      man_err = 0;
      byte_sum = '0;
      log_valid = 0;
      log_id = '0;
      log_pres = '0;
      log_temp = '0;
      log_flags = '0;
      log_time = '0;
      log_dups = '0;
      errors = 0;
      reports_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(logic [1:0] sel, logic [31:0] value);
      case (sel)
        REG_DUP_WINDOW: dup_window = value[15:0];
        REG_MAX_PRES:   max_pres = value[11:0];
        REG_MIN_TEMP:   min_temp = value[7:0];
        REG_MAX_TEMP:   max_temp = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [1:0] sel);
      case (sel)
        REG_DUP_WINDOW: return {16'd0, dup_window};
        REG_MAX_PRES:   return {20'd0, max_pres};
        REG_MIN_TEMP:   return {24'd0, min_temp};
        default:        return {24'd0, max_temp};
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // {invalid pair seen, nibble}; an invalid pair reads as 0
    function logic [4:0] manchester_nibble(logic [7:0] v);
      logic [3:0] n;
      bit bad;
      n = '0;
      bad = 0;
      for (int p = 3; p >= 0; p--) begin
        case (v[2*p +: 2])
          2'b01: n[p] = 1'b1;
          2'b10: n[p] = 1'b0;
          default: bad = 1;
        endcase
      end
      return {bad, n};
    endfunction

    function void take_byte(logic [7:0] raw, logic start, logic [31:0] now);
      logic [7:0]  shifted;
      logic [7:0]  b;
      logic [4:0]  dn;
      logic [7:0]  chk;
      logic [23:0] id;
      logic [11:0] pc;
      logic [7:0]  temp_code;
      logic [1:0]  flags;
      logic [31:0] psi;
      int          tf;
      int          k;
      report_t     r;
      if (start || byte_idx >= FRAME_BYTES) byte_idx = 0;
      if (byte_idx == 0) begin
        man_err = 0;
        byte_sum = '0;
        hi_nib = '0;
      end
      shifted = {((byte_idx == 0) ? FIRST_PREV[1:0] : prev_raw[1:0]), raw[7:2]};
      prev_raw = raw;
      dn = manchester_nibble(shifted);
      if (dn[4]) man_err = 1;
      if (byte_idx % 2 == 0) begin
        hi_nib = dn[3:0];
      end else begin
        k = byte_idx / 2;
        b = {hi_nib, dn[3:0]};
        dec[k] = b;
        if (k != 0) byte_sum = byte_sum + {3'b000, b};
      end
      byte_idx++;
      if (byte_idx < FRAME_BYTES) return;
      byte_idx = 0;

      r = '0;
      chk = {|byte_sum[10:8], byte_sum[6:0]};
      if (man_err) begin
        r.status = STAT_BAD_MAN;
      end else if (chk != dec[0]) begin
        r.status = STAT_BAD_SUM;
      end else begin
        id = {dec[1], dec[2], dec[3]};
        pc = {dec[7][3:0], dec[4]};
        temp_code = dec[5];
        flags = {dec[6][5], dec[6][4]};
        psi = 32'(pc) * 32'(PSI_SCALE);
        tf = int'(temp_code) * int'(TEMP_MUL) - int'(TEMP_OFS);
        r.sensor_id = id;
        r.pressure_code = pc;
        r.pressure_psi_q8 = psi[26:8];
        r.temp_tenths_f = tf[12:0];
        r.low_battery = flags[1];
        r.fast_leak = flags[0];
        if (id == 0 || pc > max_pres || temp_code < min_temp || temp_code > max_temp) begin
          r.status = STAT_OUT_RANGE;
        end else if (log_valid && (now - log_time) < {16'd0, dup_window} &&
                     id == log_id && pc == log_pres && temp_code == log_temp &&
                     flags == log_flags) begin
          if (log_dups != 16'hFFFF) log_dups++;
          r.status = STAT_DUP;
          r.dup_count = log_dups;
        end else begin
          log_valid = 1;
          log_id = id;
          log_pres = pc;
          log_temp = temp_code;
          log_flags = flags;
          log_time = now;
          log_dups = 16'd1;
          r.status = STAT_NEW;
          r.dup_count = 16'd1;
        end
      end
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: report with none expected, status %0d", $time, got.status);
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      status_seen[want.status]++;
      compare_field("status", want.status, got.status);
      compare_field("sensor_id", want.sensor_id, got.sensor_id);
      compare_field("pressure_code", want.pressure_code, got.pressure_code);
      compare_field("pressure_psi_q8", want.pressure_psi_q8, got.pressure_psi_q8);
      compare_field("temp_tenths_f", want.temp_tenths_f, got.temp_tenths_f);
      compare_field("low_battery", want.low_battery, got.low_battery);
      compare_field("fast_leak", want.fast_leak, got.fast_leak);
      compare_field("dup_count", want.dup_count, got.dup_count);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tpms_byte_if   byte_ch ();
  tpms_result_if result_ch ();

  tpms_frame_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  frame_decode_tracker tracker;
  idle_plan_e          idle_plan = IDLE_RECV_HEAVY;
  int                  bytes_sent = 0;
  int                  stall_cycles = 0;
  logic [31:0]         now_ms;
  logic [7:0][7:0]     last_good;
  bit                  have_good;
  bit                  need_start;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (idle_plan)
        IDLE_RECV_HEAVY: result_ch.ready <= $urandom_range(0, 99) >= 67;
        IDLE_SEND_HEAVY: result_ch.ready <= $urandom_range(0, 99) >= 29;
        default:         result_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    logic    took;
    report_t got;
    took = 1'b0;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      tracker.take_byte(byte_ch.raw_byte, byte_ch.frame_start, byte_ch.time_ms);
      took = 1'b1;
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.status = result_ch.status;
      got.sensor_id = result_ch.sensor_id;
      got.pressure_code = result_ch.pressure_code;
      got.pressure_psi_q8 = result_ch.pressure_psi_q8;
      got.temp_tenths_f = result_ch.temp_tenths_f;
      got.low_battery = result_ch.low_battery;
      got.fast_leak = result_ch.fast_leak;
      got.dup_count = result_ch.dup_count;
      tracker.check_report(got);
      took = 1'b1;
    end
    stall_cycles <= (rst || took) ? 0 : stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0][7:0] encode_frame(input logic [7:0][7:0] dec);
    logic [15:0][7:0] sym;
    logic [15:0][7:0] raw;
    logic [3:0]       nib;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      nib = (k % 2 == 0) ? dec[k/2][7:4] : dec[k/2][3:0];
      for (int p = 0; p < 4; p++) sym[k][2*p +: 2] = nib[p] ? 2'b01 : 2'b10;
    end
    // each raw byte carries the top pair of the next symbol in its low bits
    for (int k = 0; k < FRAME_BYTES; k++) begin
      raw[k] = {sym[k][5:0], (k < FRAME_BYTES - 1) ? sym[k+1][7:6] : 2'($urandom_range(0, 3))};
    end
    return raw;
  endfunction

  function automatic logic [7:0][7:0] with_checksum(input logic [7:0][7:0] dec);
    logic [10:0] s;
    s = '0;
    for (int k = 1; k < 8; k++) s = s + {3'b000, dec[k]};
    dec[0] = {s > 11'd255, s[6:0]};
    return dec;
  endfunction

  function automatic int pick_code(int lo, int hi, int top);
    int r;
    r = $urandom_range(0, 99);
    if (lo <= hi && r < 75) return $urandom_range(hi, lo);
    if (r < 85) return ((r % 2 == 1) ? hi + 1 : lo - 1) & top;
    return $urandom_range(top, 0);
  endfunction

  function automatic logic [7:0][7:0] fresh_content();
    logic [7:0][7:0] dec;
    int              pc;
    dec = {$urandom(), $urandom()};
    if ($urandom_range(0, 19) == 0) dec[3:1] = '0;
    pc = pick_code(0, tracker.max_pres, 4095);
    dec[4] = pc[7:0];
    dec[7][3:0] = pc[11:8];
    dec[5] = 8'(pick_code(tracker.min_temp, tracker.max_temp, 255));
    return with_checksum(dec);
  endfunction

  task automatic send_byte(input logic [7:0] raw, input logic start, input logic [31:0] stamp);
    int pct;
    if (bytes_sent < TOTAL_BYTES / 3) idle_plan = IDLE_RECV_HEAVY;
    else if (bytes_sent < 2 * TOTAL_BYTES / 3) idle_plan = IDLE_SEND_HEAVY;
    else idle_plan = IDLE_NONE;
    case (idle_plan)
      IDLE_RECV_HEAVY: pct = 29;
      IDLE_SEND_HEAVY: pct = 67;
      default:         pct = 0;
    endcase
    while ($urandom_range(0, 99) < pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.raw_byte <= raw;
    byte_ch.frame_start <= start;
    byte_ch.time_ms <= stamp;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0][7:0] raw, input int count, input logic first_start,
                            input bit noisy);
    for (int k = 0; k < count; k++) begin
      send_byte(raw[k], (k == 0) ? first_start : 1'(noisy && $urandom_range(0, 19) == 0),
                (k == FRAME_BYTES - 1) ? now_ms : 32'($urandom()));
    end
  endtask

  task automatic send_random_frame();
    logic [7:0][7:0]  dec;
    logic [15:0][7:0] raw;
    logic             start;
    int               kind;
    kind = $urandom_range(0, 99);
    start = need_start ? 1'b1 : 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: now_ms += $urandom_range(0, 100);
      5, 6:          now_ms += $urandom_range(0, 4000);
      7:             now_ms += tracker.dup_window - 1;
      8:             now_ms += tracker.dup_window;
      default:       now_ms += $urandom();
    endcase
    if (kind < 45 || (kind < 65 && !have_good)) begin
      dec = fresh_content();
      last_good = dec;
      have_good = 1;
      send_frame(encode_frame(dec), FRAME_BYTES, start, 0);
      need_start = 0;
    end else if (kind < 65) begin
      send_frame(encode_frame(last_good), FRAME_BYTES, start, 0);
      need_start = 0;
    end else if (kind < 75) begin
      dec = fresh_content();
      dec[0] ^= 8'($urandom_range(1, 255));
      send_frame(encode_frame(dec), FRAME_BYTES, start, 0);
      need_start = 0;
    end else if (kind < 83) begin
      raw = encode_frame(fresh_content());
      raw[$urandom_range(0, 15)] ^= 8'(1 << $urandom_range(0, 7));
      send_frame(raw, FRAME_BYTES, start, 0);
      need_start = 0;
    end else if (kind < 91) begin
      send_frame(encode_frame(fresh_content()), $urandom_range(1, 15), start, 0);
      need_start = 1;
    end else begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      send_frame(raw, FRAME_BYTES, start, 1);
      need_start = 1;
    end
  endtask

  task automatic read_check(input logic [1:0] sel);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== tracker.register_value(sel)) begin
      tracker.errors++;
      $display("%0t: register %0d read back, expected %0h, got %0h", $time, sel,
               tracker.register_value(sel), prdata);
    end
  endtask

  task automatic write_register(input logic [1:0] sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_register(sel, value);
    read_check(sel);
  endtask

  task automatic configure(input int ph);
    case (ph)
      0: begin
        read_check(REG_DUP_WINDOW);
        read_check(REG_MAX_PRES);
        read_check(REG_MIN_TEMP);
        read_check(REG_MAX_TEMP);
      end
      1: begin
        write_register(REG_DUP_WINDOW, 32'd65535);
        write_register(REG_MAX_PRES, 32'd4095);
        write_register(REG_MIN_TEMP, 32'd0);
        write_register(REG_MAX_TEMP, 32'd255);
      end
      2: begin
        write_register(REG_DUP_WINDOW, 32'd0);
        write_register(REG_MAX_PRES, 32'd0);
        write_register(REG_MIN_TEMP, 32'd255);
        write_register(REG_MAX_TEMP, 32'd0);
      end
      3: begin
        write_register(REG_DUP_WINDOW, $urandom_range(1, 5000));
        write_register(REG_MAX_PRES, $urandom_range(0, 4095));
        write_register(REG_MIN_TEMP, $urandom_range(0, 120));
        write_register(REG_MAX_TEMP, $urandom_range(100, 255));
      end
      default: begin
        write_register(REG_DUP_WINDOW, 32'(DUP_WINDOW_RST));
        write_register(REG_MAX_PRES, 32'(MAX_PRES_RST));
        write_register(REG_MIN_TEMP, 32'(MIN_TEMP_RST));
        write_register(REG_MAX_TEMP, 32'(MAX_TEMP_RST));
      end
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // a dropped partial frame gives no report, so pause past the pipeline too
  task automatic drain();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0][7:0]  dec;
    logic [15:0][7:0] raw;
    tracker = new();
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.raw_byte <= '0;
    byte_ch.frame_start <= 1'b0;
    byte_ch.time_ms <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    now_ms = 32'hFFFF_FFFF;
    have_good = 0;
    need_start = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    configure(0);

    // partial frame of extreme bytes, dropped by the next frame start
    raw = '0;
    raw[0] = 8'h00;
    raw[1] = 8'hFF;
    raw[2] = 8'h00;
    raw[3] = 8'hFF;
    raw[4] = 8'hAA;
    raw[5] = 8'h55;
    send_frame(raw, 6, 1'b1, 0);

    // all-ones id, pressure and temperature at the limits, both flags set
    dec = '0;
    dec[1] = 8'hFF;
    dec[2] = 8'hFF;
    dec[3] = 8'hFF;
    dec[4] = MAX_PRES_RST[7:0];
    dec[7] = {4'hF, MAX_PRES_RST[11:8]};
    dec[5] = MAX_TEMP_RST;
    dec[6] = 8'h30;
    dec = with_checksum(dec);
    last_good = dec;
    have_good = 1;
    send_frame(encode_frame(dec), FRAME_BYTES, 1'b1, 0);
    need_start = 0;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        configure(ph);
      end
      while (bytes_sent < TOTAL_BYTES * (ph + 1) / PHASES) send_random_frame();
    end
    drain();

    $display("Checked %0d frame reports from %0d bytes over %0d register settings",
             tracker.reports_checked, bytes_sent, PHASES);
    $display("new %0d, duplicate %0d, bad checksum %0d, bad Manchester %0d, out of range %0d",
             tracker.status_seen[STAT_NEW], tracker.status_seen[STAT_DUP],
             tracker.status_seen[STAT_BAD_SUM], tracker.status_seen[STAT_BAD_MAN],
             tracker.status_seen[STAT_OUT_RANGE]);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tpms_pkg.sv
hw/rtl/tpms_if.sv
hw/rtl/tpms_front.sv
hw/rtl/tpms_queue.sv
hw/rtl/tpms_back.sv
hw/rtl/tpms_frame_decoder.sv
hw/rtl/tpms_checker.sv
tb/sv/tb_tpms_frame_decoder.sv
